// ===== sv/lhgw_pkg.sv =====
// Shared constants and control types for the lower-hull gift-wrap block.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package lhgw_pkg;

    // Fixed port widths of the point and hull words.
    localparam int COORD_W = 32;
    localparam int INDEX_W = 6;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 32;

    // Request from the walk sequencer to the slope compare unit.
    typedef struct packed {
        logic start;
        logic neg;
    } slope_ctl_t;

    // Answer from the slope compare unit.
    typedef struct packed {
        logic done;
        logic less;
    } slope_res_t;

endpackage

`default_nettype wire

// ===== sv/lhgw_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on lhgw_pkg for its default sizes.
`default_nettype none

module lhgw_ram #(
    parameter int WIDTH = 2 * lhgw_pkg::COORD_W,
    parameter int DEPTH = lhgw_pkg::DEF_MAX_POINTS
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/lhgw_slope.sv =====
// Slope compare unit: one shared multiplier forms both cross products in
// turn and then compares them. Depends on lhgw_pkg for its control types.
`default_nettype none

module lhgw_slope #(
    parameter int W = lhgw_pkg::DEF_COORD_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lhgw_pkg::slope_ctl_t ctl,
    input  wire logic [W-1:0]        a0,
    input  wire logic [W-1:0]        b0,
    input  wire logic [W-1:0]        a1,
    input  wire logic [W-1:0]        b1,
    output lhgw_pkg::slope_res_t     res
);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_MUL0 = 4'b0010,
        P_MUL1 = 4'b0100,
        P_CMP  = 4'b1000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [W-1:0]     a0_reg, b0_reg, a1_reg, b1_reg;
    logic             neg_reg;
    logic [2*W-1:0]   prod0_reg, prod1_reg;
    logic [W-1:0]     mul_a, mul_b;
    logic [2*W-1:0]   mul_p;

    // The one multiplier; its operands follow the phase.
    assign mul_a = (phase_reg == P_MUL0) ? a0_reg : a1_reg;
    assign mul_b = (phase_reg == P_MUL0) ? b0_reg : b1_reg;
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            P_IDLE:  if (ctl.start) phase_next = P_MUL0;
            P_MUL0:  phase_next = P_MUL1;
            P_MUL1:  phase_next = P_CMP;
            P_CMP:   phase_next = P_IDLE;
            default: phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == P_IDLE && ctl.start)
        begin
            a0_reg  <= a0;
            b0_reg  <= b0;
            a1_reg  <= a1;
            b1_reg  <= b1;
            neg_reg <= ctl.neg;
        end
        if (phase_reg == P_MUL0)
        begin
            prod0_reg <= mul_p;
        end
        if (phase_reg == P_MUL1)
        begin
            prod1_reg <= mul_p;
        end
    end

    // For a falling pair of slopes the order of the products flips.
    assign res.done = (phase_reg == P_CMP);
    assign res.less = neg_reg ? (prod0_reg > prod1_reg) : (prod0_reg < prod1_reg);

endmodule

`default_nettype wire

// ===== sv/lower_hull_gift_wrap.sv =====
// Top level of the lower-hull gift-wrap block: point store, walk sequencer
// and output register. Depends on lhgw_pkg, lhgw_ram and lhgw_slope.
//
//   Channel  Handshake                  Word
//   -------  -------------------------  --------------------------------------
//   point    point_valid / point_ready  point_x, point_y, last_point
//   hull     hull_valid / hull_ready    hull_index, hull_x, hull_y, hull_last
//
// A point word is taken whenever one is offered while the block loads. After the word
// that carries last_point, the block is busy with the walk: the start search
// reads and evaluates each stored point in turn, and each chain point then
// scans every stored point again, with a cross-product compare in the shared
// multiplier for each candidate that needs one, before its word is handed over.
// Reset empties the store count and drops any pending hull word; the point
// memory is not cleared, since only entries written since the last walk are
// read. A stalled hull word holds the walk at the next hand-over.
`default_nettype none

module lower_hull_gift_wrap #(
    parameter int MAX_POINTS = lhgw_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = lhgw_pkg::DEF_COORD_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          point_valid,
    output logic                               point_ready,
    input  wire logic [lhgw_pkg::COORD_W-1:0]  point_x,
    input  wire logic [lhgw_pkg::COORD_W-1:0]  point_y,
    input  wire logic                          last_point,
    output logic                               hull_valid,
    input  wire logic                          hull_ready,
    output logic      [lhgw_pkg::INDEX_W-1:0]  hull_index,
    output logic      [lhgw_pkg::COORD_W-1:0]  hull_x,
    output logic      [lhgw_pkg::COORD_W-1:0]  hull_y,
    output logic                               hull_last
);

    // Stored coordinate width: the ports carry at most COORD_W bits.
    localparam int CW    = (COORD_BITS < lhgw_pkg::COORD_W) ? COORD_BITS : lhgw_pkg::COORD_W;
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    // Sign of a y difference, ordered so that a smaller code means a
    // smaller slope.
    localparam logic [1:0] RANK_NEG  = 2'd0;
    localparam logic [1:0] RANK_ZERO = 2'd1;
    localparam logic [1:0] RANK_POS  = 2'd2;

    typedef enum logic [6:0] {
        S_LOAD     = 7'b0000001,
        S_START_RD = 7'b0000010,
        S_START_EV = 7'b0000100,
        S_NEXT_RD  = 7'b0001000,
        S_NEXT_EV  = 7'b0010000,
        S_WAIT     = 7'b0100000,
        S_EMIT     = 7'b1000000
    } state_t;

    // Control state.
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  best_valid_reg, best_valid_next;
    logic                  hull_valid_reg, hull_valid_next;

    // Payload state.
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [CW-1:0]         xc_reg, xc_next, yc_reg, yc_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [CW-1:0]         xb_reg, xb_next, yb_reg, yb_next;
    logic [CW-1:0]         cand_x_reg, cand_x_next, cand_y_reg, cand_y_next;
    logic [lhgw_pkg::INDEX_W-1:0] hidx_reg, hidx_next;
    logic [lhgw_pkg::COORD_W-1:0] hx_reg, hx_next, hy_reg, hy_next;
    logic                  hlast_reg, hlast_next;

    // Memory and arithmetic.
    logic                  ram_we;
    logic [2*CW-1:0]       ram_rdata;
    logic [CW-1:0]         rd_x, rd_y;
    logic [CNT_W-1:0]      scan_inc;
    logic [1:0]            rank_i, rank_b;
    logic [CW-1:0]         mi, mb, dxi, dxb;
    logic                  take_rd, take_cand, advance;
    lhgw_pkg::slope_ctl_t  slope_ctl;
    lhgw_pkg::slope_res_t  slope_res;
    logic [IDX_W+lhgw_pkg::INDEX_W-1:0] idx_wide;
    logic [CW+lhgw_pkg::COORD_W-1:0]    xc_wide, yc_wide;

    assign point_ready = (state_reg == S_LOAD);
    assign ram_we      = point_valid && point_ready && (count_reg != MAX_CNT);

    // Both coordinates of a point sit side by side in one memory word.
    lhgw_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({point_y[CW-1:0], point_x[CW-1:0]}),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[CW-1:0];
    assign rd_y = ram_rdata[2*CW-1:CW];

    assign scan_inc = scan_reg + CNT_W'(1);

    // Slope operands relative to the current chain point. The candidate
    // lies strictly to the right, so both x differences are positive.
    assign rank_i = (rd_y > yc_reg) ? RANK_POS : ((rd_y < yc_reg) ? RANK_NEG : RANK_ZERO);
    assign rank_b = (yb_reg > yc_reg) ? RANK_POS : ((yb_reg < yc_reg) ? RANK_NEG : RANK_ZERO);
    assign mi     = (rd_y > yc_reg) ? (rd_y - yc_reg) : (yc_reg - rd_y);
    assign mb     = (yb_reg > yc_reg) ? (yb_reg - yc_reg) : (yc_reg - yb_reg);
    assign dxi    = rd_x - xc_reg;
    assign dxb    = xb_reg - xc_reg;

    lhgw_slope #(
        .W (CW)
    ) u_slope (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (slope_ctl),
        .a0    (mi),
        .b0    (dxb),
        .a1    (mb),
        .b1    (dxi),
        .res   (slope_res)
    );

    assign idx_wide = {{lhgw_pkg::INDEX_W{1'b0}}, cur_reg};
    assign xc_wide  = {{lhgw_pkg::COORD_W{1'b0}}, xc_reg};
    assign yc_wide  = {{lhgw_pkg::COORD_W{1'b0}}, yc_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        best_valid_next = best_valid_reg;
        hull_valid_next = hull_valid_reg;
        cur_next        = cur_reg;
        xc_next         = xc_reg;
        yc_next         = yc_reg;
        best_idx_next   = best_idx_reg;
        xb_next         = xb_reg;
        yb_next         = yb_reg;
        cand_x_next     = cand_x_reg;
        cand_y_next     = cand_y_reg;
        hidx_next       = hidx_reg;
        hx_next         = hx_reg;
        hy_next         = hy_reg;
        hlast_next      = hlast_reg;
        slope_ctl       = '{start: 1'b0, neg: 1'b0};
        take_rd         = 1'b0;
        take_cand       = 1'b0;
        advance         = 1'b0;

        // A pending hull word leaves as soon as it is taken.
        if (hull_valid_reg && hull_ready)
        begin
            hull_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                // Points beyond the store size are dropped, but their
                // last_point flag still starts the walk.
                if (point_valid)
                begin
                    if (count_reg != MAX_CNT)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_point)
                    begin
                        scan_next  = '0;
                        state_next = S_START_RD;
                    end
                end
            end
            S_START_RD:
            begin
                state_next = S_START_EV;
            end
            S_START_EV:
            begin
                // Least x, then least y; strict compares keep the earliest.
                if (scan_reg == '0 || rd_x < xc_reg || (rd_x == xc_reg && rd_y < yc_reg))
                begin
                    cur_next = scan_reg[IDX_W-1:0];
                    xc_next  = rd_x;
                    yc_next  = rd_y;
                end
                if (scan_inc == count_reg)
                begin
                    scan_next       = '0;
                    best_valid_next = 1'b0;
                    state_next      = S_NEXT_RD;
                end
                else
                begin
                    scan_next  = scan_inc;
                    state_next = S_START_RD;
                end
            end
            S_NEXT_RD:
            begin
                state_next = S_NEXT_EV;
            end
            S_NEXT_EV:
            begin
                cand_x_next = rd_x;
                cand_y_next = rd_y;
                advance     = 1'b1;
                if (rd_x > xc_reg)
                begin
                    if (!best_valid_reg)
                    begin
                        take_rd = 1'b1;
                    end
                    else if (rank_i != rank_b)
                    begin
                        take_rd = (rank_i < rank_b);
                    end
                    else if (rank_i != RANK_ZERO)
                    begin
                        // Same sign, not level: needs the cross products.
                        slope_ctl.start = 1'b1;
                        slope_ctl.neg   = (rank_i == RANK_NEG);
                        advance         = 1'b0;
                        state_next      = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (slope_res.done)
                begin
                    take_cand = slope_res.less;
                    advance   = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!hull_valid_reg || hull_ready)
                begin
                    hull_valid_next = 1'b1;
                    hidx_next       = idx_wide[lhgw_pkg::INDEX_W-1:0];
                    hx_next         = xc_wide[lhgw_pkg::COORD_W-1:0];
                    hy_next         = yc_wide[lhgw_pkg::COORD_W-1:0];
                    hlast_next      = !best_valid_reg;
                    if (best_valid_reg)
                    begin
                        cur_next        = best_idx_reg;
                        xc_next         = xb_reg;
                        yc_next         = yb_reg;
                        best_valid_next = 1'b0;
                        scan_next       = '0;
                        state_next      = S_NEXT_RD;
                    end
                    else
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (take_rd)
        begin
            best_valid_next = 1'b1;
            best_idx_next   = scan_reg[IDX_W-1:0];
            xb_next         = rd_x;
            yb_next         = rd_y;
        end
        if (take_cand)
        begin
            best_valid_next = 1'b1;
            best_idx_next   = scan_reg[IDX_W-1:0];
            xb_next         = cand_x_reg;
            yb_next         = cand_y_reg;
        end
        if (advance)
        begin
            if (scan_inc == count_reg)
            begin
                state_next = S_EMIT;
            end
            else
            begin
                scan_next  = scan_inc;
                state_next = S_NEXT_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            scan_reg       <= '0;
            best_valid_reg <= 1'b0;
            hull_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            best_valid_reg <= best_valid_next;
            hull_valid_reg <= hull_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        xc_reg       <= xc_next;
        yc_reg       <= yc_next;
        best_idx_reg <= best_idx_next;
        xb_reg       <= xb_next;
        yb_reg       <= yb_next;
        cand_x_reg   <= cand_x_next;
        cand_y_reg   <= cand_y_next;
        hidx_reg     <= hidx_next;
        hx_reg       <= hx_next;
        hy_reg       <= hy_next;
        hlast_reg    <= hlast_next;
    end

    assign hull_valid = hull_valid_reg;
    assign hull_index = hidx_reg;
    assign hull_x     = hx_reg;
    assign hull_y     = hy_reg;
    assign hull_last  = hlast_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("point count beyond store size");

    a_best_right: assert property (@(posedge clk) disable iff (!rst_n)
        best_valid_reg |-> (xb_reg > xc_reg))
        else $error("best candidate not right of current point");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        slope_res.done |-> (state_reg == S_WAIT))
        else $error("slope result outside wait state");

    a_start_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        slope_ctl.start |=> (state_reg == S_WAIT && !slope_res.done))
        else $error("slope compare start not followed by wait");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START_RD) |-> (count_reg != '0))
        else $error("walk started on an empty store");

endmodule

`default_nettype wire

// ===== dv/lower_hull_gift_wrap_tb.sv =====
`timescale 1ns / 1ps
// Testbench for lower_hull_gift_wrap: loads point sets and checks the emitted lower chain.
// Depends on lhgw_pkg and the lower_hull_gift_wrap RTL; the chain predictor lives in the class.

// Keeps its own copy of the point store. When the final point of a set is
// noted, it walks the lower chain and queues the hull words it expects.
class hull_scoreboard;
    typedef struct {
        bit [lhgw_pkg::INDEX_W-1:0] index;
        bit [lhgw_pkg::COORD_W-1:0] x;
        bit [lhgw_pkg::COORD_W-1:0] y;
        bit                         last;
    } hull_word_t;

    bit [lhgw_pkg::COORD_W-1:0] x_mem [lhgw_pkg::DEF_MAX_POINTS];
    bit [lhgw_pkg::COORD_W-1:0] y_mem [lhgw_pkg::DEF_MAX_POINTS];
    int unsigned                stored;
    hull_word_t                 chain_q[$];
    int unsigned                mismatches;

    function new();
        stored     = 0;
        mismatches = 0;
    endfunction

    // True when the slope from cur to cand is strictly below the slope to best.
    // Both candidates lie strictly right of cur, so the x distances are positive.
    function bit slope_below(int cur, int cand, int best);
        bit [31:0] yc, yi, yb, dxi, dxb, mi, mb;
        bit [63:0] lhs, rhs;
        int        si, sb;
        yc  = y_mem[cur];
        yi  = y_mem[cand];
        yb  = y_mem[best];
        dxi = x_mem[cand] - x_mem[cur];
        dxb = x_mem[best] - x_mem[cur];
        si  = (yi > yc) ? 1 : ((yi < yc) ? -1 : 0);
        sb  = (yb > yc) ? 1 : ((yb < yc) ? -1 : 0);
        mi  = (yi >= yc) ? yi - yc : yc - yi;
        mb  = (yb >= yc) ? yb - yc : yc - yb;
        lhs = 64'(mi) * 64'(dxb);
        rhs = 64'(mb) * 64'(dxi);
        if (si != sb)
            return si < sb;
        if (si == 0)
            return 1'b0;
        if (si > 0)
            return lhs < rhs;
        return lhs > rhs;
    endfunction

    function void note_point(bit [31:0] x, bit [31:0] y, bit last);
        int         cur;
        int         best;
        int         emitted;
        hull_word_t w;
        if (stored < lhgw_pkg::DEF_MAX_POINTS) begin
            x_mem[stored] = x;
            y_mem[stored] = y;
            stored++;
        end
        if (!last)
            return;
        cur = 0;
        for (int i = 1; i < stored; i++) begin
            if (x_mem[i] < x_mem[cur] || (x_mem[i] == x_mem[cur] && y_mem[i] < y_mem[cur]))
                cur = i;
        end
        emitted = 0;
        forever begin
            best = -1;
            for (int i = 0; i < stored; i++) begin
                if (x_mem[i] <= x_mem[cur])
                    continue;
                if (best < 0 || slope_below(cur, i, best))
                    best = i;
            end
            w.index = cur[lhgw_pkg::INDEX_W-1:0];
            w.x     = x_mem[cur];
            w.y     = y_mem[cur];
            w.last  = (best < 0);
            chain_q.push_back(w);
            emitted++;
            if (best < 0 || emitted >= lhgw_pkg::DEF_MAX_POINTS)
                break;
            cur = best;
        end
        stored = 0;
    endfunction

    function void check_hull(bit [5:0] index, bit [31:0] x, bit [31:0] y, bit last);
        hull_word_t w;
        if (chain_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected hull word: idx %0d x %h y %h last %b", index, x, y, last);
            return;
        end
        w = chain_q.pop_front();
        if (w.index != index || w.x != x || w.y != y || w.last != last) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"hull word mismatch: expected idx %0d x %h y %h last %b, ",
                          "got idx %0d x %h y %h last %b"},
                         w.index, w.x, w.y, w.last, index, x, y, last);
        end
    endfunction
endclass

module lower_hull_gift_wrap_tb;

    // Cycles with no word accepted on either channel before the run is abandoned.
    // The longest honest gap is one chain point over a full store: a read and an
    // evaluation per point of search, a cross-product compare per candidate that
    // needs one and the hand-over, plus the start search and whatever the receiver stalls.
    localparam int QUIET_LIMIT  = 6000;
    localparam int DRAIN_CYCLES = 800;
    localparam int TARGET_WORDS = 450;

    // Shape of the coordinates of one random point set.
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_GRID,
        SHAPE_BOWL,
        SHAPE_EDGES
    } set_shape_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          point_valid = 1'b0;
    logic                          point_ready;
    logic [lhgw_pkg::COORD_W-1:0]  point_x     = '0;
    logic [lhgw_pkg::COORD_W-1:0]  point_y     = '0;
    logic                          last_point  = 1'b0;
    logic                          hull_valid;
    logic                          hull_ready  = 1'b0;
    logic [lhgw_pkg::INDEX_W-1:0]  hull_index;
    logic [lhgw_pkg::COORD_W-1:0]  hull_x;
    logic [lhgw_pkg::COORD_W-1:0]  hull_y;
    logic                          hull_last;

    hull_scoreboard sb;
    int unsigned    words_sent     = 0;
    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    quiet_cycles   = 0;

    lower_hull_gift_wrap uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_point  (last_point),
        .hull_valid  (hull_valid),
        .hull_ready  (hull_ready),
        .hull_index  (hull_index),
        .hull_x      (hull_x),
        .hull_y      (hull_y),
        .hull_last   (hull_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offers one point word and returns at the edge where it is taken. Valid is
    // only lowered inside the idle loop, so back-to-back words keep it high
    // without a second assignment in the same time step.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point_x     <= x;
        point_y     <= y;
        last_point  <= last;
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
        // The word was taken at this edge; the chain it closes is predicted now.
        sb.note_point(x, y, last);
        words_sent++;
    endtask

    // Values on or next to the ends of the coordinate range, or a random one.
    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 6))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'hFFFF_FFFE;
            4:       return 32'h8000_0000;
            5:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // One complete point set. Most sets are small so the walk stays short; a
    // few fill the store exactly and a few overflow it, which checks that
    // extra points are dropped while the final flag still starts the walk.
    task automatic send_random_set();
        int unsigned sel;
        int unsigned count;
        int unsigned base_x;
        int unsigned base_y;
        int unsigned step;
        int unsigned mult;
        int unsigned rot;
        int          k;
        set_shape_t  shape;
        logic [31:0] x;
        logic [31:0] y;
        sel = $urandom_range(0, 99);
        if (sel < 78)
            count = $urandom_range(1, 10);
        else if (sel < 90)
            count = $urandom_range(11, 30);
        else if (sel < 96)
            count = lhgw_pkg::DEF_MAX_POINTS;
        else
            count = $urandom_range(lhgw_pkg::DEF_MAX_POINTS + 1, lhgw_pkg::DEF_MAX_POINTS + 6);
        shape  = set_shape_t'($urandom_range(0, 3));
        base_x = $urandom_range(0, 1) ? 32'hFFFF_FFF0 : $urandom_range(0, 1000);
        base_y = $urandom_range(0, 1) ? 32'hFFFF_FFF0 : $urandom_range(0, 1000);
        step   = $urandom_range(1, 1 << 20);
        mult   = $urandom_range(1, 1 << 21);
        rot    = $urandom_range(0, 63);
        for (int i = 0; i < count; i++)
        begin
            case (shape)
                SHAPE_RANDOM:
                begin
                    x = $urandom();
                    y = $urandom();
                end
                // A tiny grid gives shared x values, duplicates and collinear runs.
                SHAPE_GRID:
                begin
                    x = base_x + $urandom_range(0, 7);
                    y = base_y + $urandom_range(0, 7);
                end
                // Points on a parabola, loaded out of order, give a long chain
                // whose slopes fall and then rise.
                SHAPE_BOWL:
                begin
                    k = (i * 37 + rot) % 64;
                    x = base_x[30:0] + k * step;
                    y = (k - 32) * (k - 32) * mult + $urandom_range(0, 1 << 29);
                end
                default:
                begin
                    x = edge_value();
                    y = edge_value();
                end
            endcase
            send_point(x, y, i == count - 1);
        end
    endtask

    // Hull side: check what was taken at this edge, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n && hull_valid && hull_ready)
            sb.check_hull(hull_index, hull_x, hull_y, hull_last);
        hull_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (point_valid && point_ready) || (hull_valid && hull_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no word accepted for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lone points at both corners of the range: a chain of one point.
        send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        // Corners of the range, a duplicate of the start point and points
        // straddling the middle; the chain steps flat from the start point across
        // the largest x distance.
        send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

        // Collinear points with duplicates: every slope ties, so the earliest
        // loaded point of the tie must be taken next.
        send_point(32'd30, 32'd30, 1'b0);
        send_point(32'd10, 32'd10, 1'b0);
        send_point(32'd20, 32'd20, 1'b0);
        send_point(32'd20, 32'd20, 1'b0);
        send_point(32'd30, 32'd30, 1'b0);
        send_point(32'd50, 32'd50, 1'b1);

        // Several points share the start x; none of them may follow the start.
        send_point(32'd5, 32'd9, 1'b0);
        send_point(32'd5, 32'd1, 1'b0);
        send_point(32'd5, 32'd4, 1'b0);
        send_point(32'd6, 32'd100, 1'b1);

        // Full-range descent from the start point to the far corner.
        send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);

        // Random sets, one idling phase per quarter of the words: none, a slow
        // sender, a slow receiver, then light idling on both sides.
        while (words_sent < TARGET_WORDS)
        begin
            case (words_sent * 4 / TARGET_WORDS)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            send_random_set();
        end
        point_valid <= 1'b0;

        // Let the last chain come out, then give any stray word time to show.
        while (sb.chain_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.chain_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
